@@ hdl/assert_macros.svh @@
// Assertion macros shared by the indexed list engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ile_pkg.sv @@
// Shared constants, operation codes and control structs of the indexed list engine.
// No dependencies; imported by every module of the block.
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
    localparam int DATA_W   = 32;
    localparam int GRP_SIZE = 32;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [2:0] OP_GET  = 3'd0;
    localparam logic [2:0] OP_HEAD = 3'd1;
    localparam logic [2:0] OP_TAIL = 3'd2;
    localparam logic [2:0] OP_AT   = 3'd3;
    localparam logic [2:0] OP_DEL  = 3'd4;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cell_ctl;

    typedef struct packed {
        logic             en;
        logic [CMP_W-1:0] pos;
    } t_read_ctl;

endpackage

@@ hdl/ile_cell.sv @@
// One storage cell of the list chain: holds one element and shifts with its neighbors.
// Depends on ile_pkg for widths and the control structs.
module ile_cell (
    input  logic                      i_clk,
    input  logic [ile_pkg::IDX_W-1:0]  i_index,
    input  ile_pkg::t_cell_ctl         i_ctl,
    input  ile_pkg::t_read_ctl         i_rd,
    input  logic [ile_pkg::DATA_W-1:0] i_prev,
    input  logic [ile_pkg::DATA_W-1:0] i_next,
    output logic [ile_pkg::DATA_W-1:0] o_value,
    output logic [ile_pkg::DATA_W-1:0] o_tap
);
    import ile_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic [CMP_W-1:0]  w_idx;

    assign w_idx = CMP_W'(i_index);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (w_idx > i_ctl.pos) begin
                n_val = i_prev;
            end else if (w_idx == i_ctl.pos) begin
                n_val = i_ctl.val;
            end
        end else if (i_ctl.del) begin
            if (w_idx >= i_ctl.pos) begin
                n_val = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_tap   = (i_rd.en && (w_idx == i_rd.pos)) ? r_val : '0;

endmodule

@@ hdl/ile_or_tree.sv @@
// Registered two-level OR tree that collects the one selected cell value.
// Depends on ile_pkg for the capacity and grouping constants.
module ile_or_tree (
    input  logic                      i_clk,
    input  logic [ile_pkg::DATA_W-1:0] i_taps [ile_pkg::CAPACITY],
    output logic [ile_pkg::DATA_W-1:0] o_merged
);
    import ile_pkg::*;

    logic [DATA_W-1:0] r_grp [NUM_GRP];
    logic [DATA_W-1:0] n_grp [NUM_GRP];

    always_comb begin
        for (int j = 0; j < NUM_GRP; j++) begin
            n_grp[j] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (j * GRP_SIZE + k < CAPACITY) begin
                    n_grp[j] = n_grp[j] | i_taps[j * GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_GRP; j++) begin
            r_grp[j] <= n_grp[j];
        end
    end

    always_comb begin
        o_merged = '0;
        for (int j = 0; j < NUM_GRP; j++) begin
            o_merged = o_merged | r_grp[j];
        end
    end

endmodule

@@ hdl/indexed_list_engine.sv @@
// Indexed list engine: an ordered list of signed 32-bit values kept in a chain of cells.
// Depends on ile_pkg, ile_cell, ile_or_tree and assert_macros.svh.
//
// The block holds up to CAPACITY elements, element i in cell i, and answers get, insert at
// head, insert at tail, insert at index and delete requests with one result each. Inserts and
// deletes move every later element by one place in the cycle the transaction is accepted.
// A get is collected through a two-level registered OR tree over the cells. Every request
// passes through the states S_IDLE, where it is accepted, S_GATHER and S_MERGE, where its
// result is loaded into the output register. The block works on one transaction at a time:
// a new transaction is taken only in S_IDLE, after the previous result has been loaded. A
// waiting result does not block acceptance of the next transaction. There is no clearing
// pass after reset; cells beyond the length are never read.
`include "assert_macros.svh"

module indexed_list_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [2:0]                i_op,
    input  logic [6:0]                i_position,
    input  logic signed [31:0]        i_item_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [31:0]        o_read_value,
    output logic                      o_ok,
    output logic [6:0]                o_length
);
    import ile_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GATHER = 2'd1;
    localparam logic [1:0] S_MERGE  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ok;
    t_read_ctl         r_rd;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    logic              r_o_ok;
    logic [6:0]        r_o_len;

    logic              w_accept;
    logic              w_load;
    logic              w_done;
    logic              w_full;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_cnt;
    t_cell_ctl         w_ctl;
    t_read_ctl         w_rd;
    logic [DATA_W-1:0] w_merged;
    logic [DATA_W-1:0] w_val  [CAPACITY];
    logic [DATA_W-1:0] w_tap  [CAPACITY];
    logic [DATA_W-1:0] w_prev [CAPACITY];
    logic [DATA_W-1:0] w_next [CAPACITY];

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_pos    = CMP_W'(i_position);
    assign w_cnt    = CMP_W'(r_count);
    assign w_full   = (w_cnt == CMP_W'(CAPACITY));

    always_comb begin
        w_done    = 1'b0;
        w_ctl.ins = 1'b0;
        w_ctl.del = 1'b0;
        w_ctl.pos = w_pos;
        w_ctl.val = i_item_value;
        w_rd.en   = 1'b0;
        w_rd.pos  = w_pos;
        unique case (i_op)
            OP_GET: begin
                w_done  = (w_pos < w_cnt);
                w_rd.en = w_done;
            end
            OP_HEAD: begin
                w_done    = !w_full;
                w_ctl.pos = '0;
                w_ctl.ins = w_done;
            end
            OP_TAIL: begin
                w_done    = !w_full;
                w_ctl.pos = w_cnt;
                w_ctl.ins = w_done;
            end
            OP_AT: begin
                w_done    = !w_full && (w_pos <= w_cnt);
                w_ctl.ins = w_done;
            end
            OP_DEL: begin
                w_done    = (w_pos < w_cnt);
                w_ctl.del = w_done;
            end
            default: begin
                w_done = 1'b0;
            end
        endcase
        if (!w_accept) begin
            w_ctl.ins = 1'b0;
            w_ctl.del = 1'b0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_load = (r_state == S_MERGE) && (!r_o_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_rd.en   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_accept) begin
                r_rd <= w_rd;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= w_done;
        end
        if (w_load) begin
            r_o_value <= r_rd.en ? w_merged : '1;
            r_o_ok    <= r_ok;
            r_o_len   <= w_cnt[6:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g] = '0;
            end else begin : g_mid_prev
                assign w_prev[g] = w_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_next[g] = '0;
            end else begin : g_mid_next
                assign w_next[g] = w_val[g+1];
            end
            ile_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(g)),
                .i_ctl   (w_ctl),
                .i_rd    (r_rd),
                .i_prev  (w_prev[g]),
                .i_next  (w_next[g]),
                .o_value (w_val[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    ile_or_tree u_or_tree (
        .i_clk    (i_clk),
        .i_taps   (w_tap),
        .o_merged (w_merged)
    );

    assign o_valid      = r_o_valid;
    assign o_read_value = r_o_value;
    assign o_ok         = r_o_ok;
    assign o_length     = r_o_len;

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, w_cnt <= CMP_W'(CAPACITY), "count above capacity")
    `ASSERT_NEXT(a_accept_gather, i_clk, i_rst_n, w_accept, r_state == S_GATHER, "accept did not start gather")
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_MERGE) && r_o_valid && i_stall, (r_state == S_MERGE) && o_valid, "pending result lost while output stalled")
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, w_ctl.ins, r_count == CNT_W'($past(r_count) + 1'b1), "insert did not grow the list")
    `ASSERT_NEXT(a_delete_count, i_clk, i_rst_n, w_ctl.del, r_count == CNT_W'($past(r_count) - 1'b1), "delete did not shrink the list")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_engine: a directed table, then random request
// traffic with idle and stall gaps, checked against a behavioral model of the list.
// Depends on ile_pkg and the indexed_list_engine RTL.
module tb;
    import ile_pkg::*;

    localparam logic [2:0]  OP_RSVD_LO     = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI     = 3'd7;
    localparam logic [31:0] READ_NONE      = 32'hFFFF_FFFF;
    localparam int          DIRECTED_ROWS  = 23;
    localparam int          RANDOM_ITEMS   = 1275;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          MAX_PRINTS     = 50;

    typedef struct packed {
        logic [31:0] read_value;
        logic        ok;
        logic [6:0]  length;
    } t_list_result;

    typedef struct packed {
        logic [2:0]   op;
        logic [6:0]   position;
        logic [31:0]  item_value;
        logic         typed;
        t_list_result want;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_op;
    logic [6:0]         i_position;
    logic signed [31:0] i_item_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_read_value;
    logic               o_ok;
    logic [6:0]         o_length;

    logic [31:0]  list_cells [CAPACITY];
    int           list_len;
    t_list_result pending_results [$];
    int           mismatch_count;
    int           quiet_cycles;
    bit           quiet_stretch;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_GET,     7'd0,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b0, 7'd0}},
        '{OP_DEL,     7'd0,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b0, 7'd0}},
        '{OP_AT,      7'd1,   32'h0000_0005, 1'b1, '{READ_NONE,     1'b0, 7'd0}},
        '{OP_RSVD_LO, 7'd0,   32'h1234_5678, 1'b1, '{READ_NONE,     1'b0, 7'd0}},
        '{OP_AT,      7'd0,   32'h7FFF_FFFF, 1'b1, '{READ_NONE,     1'b1, 7'd1}},
        '{OP_GET,     7'd0,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 7'd1}},
        '{OP_DEL,     7'd0,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b1, 7'd0}},
        '{OP_HEAD,    7'd0,   32'h8000_0000, 1'b1, '{READ_NONE,     1'b1, 7'd1}},
        '{OP_TAIL,    7'd0,   32'hFFFF_FFFF, 1'b1, '{READ_NONE,     1'b1, 7'd2}},
        '{OP_AT,      7'd1,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b1, 7'd3}},
        '{OP_GET,     7'd0,   32'h0000_0000, 1'b0, '0},
        '{OP_GET,     7'd1,   32'h0000_0000, 1'b0, '0},
        '{OP_GET,     7'd2,   32'h0000_0000, 1'b0, '0},
        '{OP_GET,     7'h7F,  32'h0000_0000, 1'b1, '{READ_NONE,     1'b0, 7'd3}},
        '{OP_DEL,     7'h7F,  32'h0000_0000, 1'b1, '{READ_NONE,     1'b0, 7'd3}},
        '{OP_AT,      7'h7F,  32'h0000_0001, 1'b1, '{READ_NONE,     1'b0, 7'd3}},
        '{OP_AT,      7'd4,   32'h0000_0002, 1'b1, '{READ_NONE,     1'b0, 7'd3}},
        '{OP_AT,      7'd3,   32'h5555_AAAA, 1'b1, '{READ_NONE,     1'b1, 7'd4}},
        '{OP_RSVD_HI, 7'h7F,  32'hFFFF_FFFF, 1'b1, '{READ_NONE,     1'b0, 7'd4}},
        '{OP_DEL,     7'd1,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b1, 7'd3}},
        '{OP_GET,     7'd3,   32'h0000_0000, 1'b1, '{READ_NONE,     1'b0, 7'd3}},
        '{OP_GET,     7'd2,   32'h0000_0000, 1'b0, '0},
        '{OP_AT,      7'd0,   32'h2AAA_5555, 1'b0, '0}
    };

    indexed_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_ok         (o_ok),
        .o_length     (o_length)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit list_insert(input int at, input logic [31:0] value);
        if (list_len >= CAPACITY || at > list_len) return 1'b0;
        for (int i = list_len; i > at; i--) list_cells[i] = list_cells[i - 1];
        list_cells[at] = value;
        list_len++;
        return 1'b1;
    endfunction

    function automatic t_list_result list_apply(input logic [2:0] op, input logic [6:0] pos,
                                                input logic [31:0] value);
        t_list_result r;
        r.read_value = READ_NONE;
        r.ok         = 1'b0;
        case (op)
            OP_GET: begin
                if (int'(pos) < list_len) begin
                    r.read_value = list_cells[pos];
                    r.ok         = 1'b1;
                end
            end
            OP_HEAD: r.ok = list_insert(0, value);
            OP_TAIL: r.ok = list_insert(list_len, value);
            OP_AT:   r.ok = list_insert(int'(pos), value);
            OP_DEL: begin
                if (int'(pos) < list_len) begin
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.length = list_len[6:0];
        return r;
    endfunction

    function automatic logic [2:0] pick_op(input int phase);
        int ins_pct;
        int del_pct;
        int r;
        case (phase)
            0:       begin ins_pct = 85; del_pct = 5;  end
            2:       begin ins_pct = 5;  del_pct = 80; end
            default: begin ins_pct = 40; del_pct = 35; end
        endcase
        if ($urandom_range(99) < 4) return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
        r = $urandom_range(99);
        if (r < ins_pct) begin
            case ($urandom_range(2))
                0:       return OP_HEAD;
                1:       return OP_TAIL;
                default: return OP_AT;
            endcase
        end
        if (r < ins_pct + del_pct) return OP_DEL;
        return OP_GET;
    endfunction

    function automatic logic [6:0] pick_position(input logic [2:0] op);
        if ($urandom_range(99) < 15) return 7'($urandom_range(127));
        if (op == OP_AT) return 7'($urandom_range(list_len));
        if (list_len > 0) return 7'($urandom_range(list_len - 1));
        return 7'd0;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance of the transaction.
    task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                                input logic [31:0] value, input bit typed,
                                input t_list_result want);
        t_list_result predicted;
        while (!quiet_stretch && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_position   <= pos;
        i_item_value <= value;
        do @(posedge i_clk); while (o_stall);
        predicted = list_apply(op, pos, value);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) i_stall <= !quiet_stretch && ($urandom_range(99) < 9);

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: value %h ok %b len %0d",
                                          o_read_value, o_ok, o_length));
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %h expected %h",
                                              o_read_value, want.read_value));
                if (o_ok !== want.ok)
                    report_mismatch($sformatf("ok got %b expected %b", o_ok, want.ok));
                if (o_length !== want.length)
                    report_mismatch($sformatf("length got %0d expected %0d",
                                              o_length, want.length));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int         counted;
        bit         paused;
        logic [2:0] op;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_op           = OP_GET;
        i_position     = 7'd0;
        i_item_value   = 32'sd0;
        list_len       = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        quiet_stretch  = 1'b0;
        counted        = 0;
        paused         = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
            send_request(directed_rows[n].op, directed_rows[n].position,
                         directed_rows[n].item_value, directed_rows[n].typed,
                         directed_rows[n].want);
        wait_all_results();

        while (counted < RANDOM_ITEMS) begin
            quiet_stretch = (counted >= 300 && counted < 500);
            if (counted == 700 && !paused) begin
                wait_all_results();
                paused = 1'b1;
            end
            op = pick_op((counted / 100) % 4);
            send_request(op, pick_position(op), pick_value(), 1'b0, '0);
            if (op <= OP_DEL) counted++;
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/ile_or_tree.sv
hdl/indexed_list_engine.sv
sim/tb.sv
